// ----- design/gossip_dedup_router_assert.svh -----
// ----------------------------------------------------------------------------
// Router assertion macros
// Concurrent assertion shorthands shared by the router RTL.
// ----------------------------------------------------------------------------
`ifndef GOSSIP_DEDUP_ROUTER_ASSERT_SVH
`define GOSSIP_DEDUP_ROUTER_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define GDR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define GDR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/gdr_pkg.sv -----
// ----------------------------------------------------------------------------
// Gossip router package
// Shared constants and types for the flood router with duplicate cache.
// ----------------------------------------------------------------------------
package gdr_pkg;
  localparam int CACHE_DEPTH = 256;
  localparam int IDX_W = $clog2(CACHE_DEPTH);
  localparam int CNT_W = IDX_W + 1;

  localparam logic [1:0] FUNC_RECV  = 2'd0;
  localparam logic [1:0] FUNC_BCAST = 2'd1;
  localparam logic [1:0] FUNC_TARG  = 2'd2;
  localparam logic [1:0] FUNC_TICK  = 2'd3;

  localparam logic [1:0] ACT_LOCAL = 2'd0;
  localparam logic [1:0] ACT_FLOOD = 2'd1;
  localparam logic [1:0] ACT_ROUTE = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  localparam logic [2:0] REG_SELF  = 3'd0;
  localparam logic [2:0] REG_MAX   = 3'd1;
  localparam logic [2:0] REG_TTL   = 3'd2;
  localparam logic [2:0] REG_HOPS  = 3'd3;
  localparam logic [2:0] REG_SEED  = 3'd4;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] msg_origin;
    logic [63:0] msg_seq;
    logic [63:0] src_id;
    logic [63:0] dst_id;
    logic [7:0]  hop_ttl;
    logic [7:0]  inbound_link;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  action;
    logic        was_duplicate;
    logic [63:0] out_src;
    logic [63:0] out_dst;
    logic [63:0] out_origin;
    logic [63:0] out_seq;
    logic [7:0]  out_ttl;
    logic [7:0]  except_link;
    logic        has_except;
    logic        last;
  } out_word_t;

  // Command from the sequencer to the cache unit.
  typedef struct packed {
    logic        lookup;
    logic        tick;
    logic [63:0] origin;
    logic [63:0] seq;
  } cache_cmd_t;

  // Status back from the cache unit.
  typedef struct packed {
    logic done;
    logic hit;
  } cache_sts_t;
endpackage

// ----- design/gdr_if.sv -----
// ----------------------------------------------------------------------------
// Router channel interface
// Valid/ready channel carrying one word of the given payload type.
// ----------------------------------------------------------------------------
interface gdr_in_if import gdr_pkg::*; (input logic clk);
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gdr_out_if import gdr_pkg::*; (input logic clk);
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/gossip_dedup_router.sv -----
// From accept to first result word, a lookup compares each cached id in turn, then on a
// hit finishes or on a miss trims entries down under the cap and inserts; a tick evicts
// aged entries, and a targeted word to this node skips the cache. One word is handled at
// a time and the input is ready again in the cycle the last result word is presented.
// Synchronous active-low reset restores pointers, time and registers; memory is kept.
// ----------------------------------------------------------------------------
// Gossip dedup router
// Flood router deciding delivery and forwarding with a duplicate cache.
// ----------------------------------------------------------------------------
module gossip_dedup_router import gdr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  gdr_in_if.sink      in_ch,
  gdr_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
`include "gossip_dedup_router_assert.svh"

  typedef enum logic [1:0] {S_IDLE, S_WAIT, S_OUT1, S_OUT2} st_t;

  st_t        st_r;
  logic [63:0] self_r, ctr_r;
  logic [8:0] max_r;
  logic [15:0] ttl_r;
  logic [7:0] hops_r;
  in_word_t   it_r;
  out_word_t  o1_r, o2_r;
  logic       two_r;
  logic       ovalid_r;
  out_word_t  odata_r;
  cache_cmd_t cmd;
  cache_sts_t sts;
  logic       acc;
  logic [63:0] ctr_inc;

  gdr_cache u_cache (.clk(clk), .rst_n(rst_n), .max_entries(max_r),
                     .dedup_ttl(ttl_r), .cmd(cmd), .sts(sts));

  assign acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (st_r == S_IDLE);
  assign out_ch.valid = ovalid_r;
  assign out_ch.data = odata_r;
  assign ctr_inc = ctr_r + 64'd1;

  // Commands to the cache are issued in the accept cycle.
  always_comb begin
    cmd.lookup = 1'b0;
    cmd.tick = 1'b0;
    cmd.origin = in_ch.data.msg_origin;
    cmd.seq = in_ch.data.msg_seq;
    if (acc) begin
      unique case (in_ch.data.func)
        FUNC_RECV: cmd.lookup = 1'b1;
        FUNC_BCAST: begin
          cmd.lookup = 1'b1;
          cmd.origin = self_r;
          cmd.seq = ctr_inc;
        end
        FUNC_TARG: begin
          cmd.lookup = (in_ch.data.dst_id != self_r);
          cmd.origin = self_r;
          cmd.seq = ctr_inc;
        end
        default: cmd.tick = 1'b1;
      endcase
    end
  end

  // Sequencer, configuration and output register.
  always_ff @(posedge clk) begin
    out_word_t a, b;
    logic n2, have1;
    if (!rst_n) begin
      st_r <= S_IDLE;
      self_r <= '0;
      max_r <= 9'd256;
      ttl_r <= 16'd60;
      hops_r <= 8'd8;
      ctr_r <= '0;
      ovalid_r <= 1'b0;
      two_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SELF: self_r <= cfg_data;
          REG_MAX:  max_r <= cfg_data[8:0];
          REG_TTL:  ttl_r <= cfg_data[15:0];
          REG_HOPS: hops_r <= cfg_data[7:0];
          REG_SEED: ctr_r <= cfg_data;
          default: ;
        endcase
      end
      // The output register empties when taken, unless it is reloaded below.
      if (ovalid_r && out_ch.ready && st_r != S_OUT2) ovalid_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (acc) begin
            it_r <= in_ch.data;
            if (in_ch.data.func == FUNC_BCAST ||
                (in_ch.data.func == FUNC_TARG && in_ch.data.dst_id != self_r))
              ctr_r <= ctr_inc;
            if (in_ch.data.func == FUNC_TARG && in_ch.data.dst_id == self_r)
              st_r <= S_OUT1;
            else
              st_r <= S_WAIT;
          end
        end
        S_WAIT: if (sts.done) st_r <= S_OUT1;
        S_OUT1: begin
          // Build the results for the finished item.
          a = '0;
          b = '0;
          n2 = 1'b0;
          have1 = 1'b1;
          a.action = ACT_NONE;
          unique case (it_r.func)
            FUNC_RECV: begin
              if (sts.hit) begin
                a.was_duplicate = 1'b1;
              end else begin
                b.out_src = it_r.src_id;
                b.out_dst = it_r.dst_id;
                b.out_origin = it_r.msg_origin;
                b.out_seq = it_r.msg_seq;
                b.out_ttl = it_r.hop_ttl - 8'd1;
                b.except_link = it_r.inbound_link;
                b.has_except = 1'b1;
                a.out_src = it_r.src_id;
                a.out_dst = it_r.dst_id;
                a.out_origin = it_r.msg_origin;
                a.out_seq = it_r.msg_seq;
                a.action = ACT_LOCAL;
                if (it_r.dst_id == '0) begin
                  b.action = ACT_FLOOD;
                  if (it_r.src_id != self_r) begin
                    n2 = (it_r.hop_ttl > 8'd1);
                  end else if (it_r.hop_ttl > 8'd1) begin
                    a = b;
                  end else begin
                    have1 = 1'b0;
                  end
                end else if (it_r.dst_id != self_r) begin
                  b.action = ACT_ROUTE;
                  if (it_r.hop_ttl > 8'd1) a = b;
                  else have1 = 1'b0;
                end
              end
            end
            FUNC_BCAST: begin
              a.action = ACT_FLOOD;
              a.out_src = self_r;
              a.out_origin = self_r;
              a.out_seq = ctr_r;
              a.out_ttl = hops_r;
            end
            FUNC_TARG: begin
              if (it_r.dst_id == self_r) begin
                a.action = ACT_LOCAL;
                a.out_src = self_r;
                a.out_dst = self_r;
              end else begin
                a.action = ACT_ROUTE;
                a.out_src = self_r;
                a.out_dst = it_r.dst_id;
                a.out_origin = self_r;
                a.out_seq = ctr_r;
                a.out_ttl = hops_r;
              end
            end
            default: ;
          endcase
          if (!have1) begin
            a = '0;
            a.action = ACT_NONE;
          end
          a.last = !n2;
          b.last = 1'b1;
          o2_r <= b;
          two_r <= n2;
          o1_r <= a;
          st_r <= S_OUT2;
        end
        S_OUT2: begin
          // Hand results to the output register one word at a time.
          if (!ovalid_r || out_ch.ready) begin
            ovalid_r <= 1'b1;
            odata_r <= o1_r;
            if (two_r) begin
              o1_r <= o2_r;
              two_r <= 1'b0;
            end else begin
              st_r <= S_IDLE;
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  `GDR_ASSERT_IMP(a_busy_not_ready, clk, rst_n, st_r != S_IDLE, !in_ch.ready)
  `GDR_ASSERT_NXT(a_accept_leaves_idle, clk, rst_n, acc, st_r != S_IDLE)
  `GDR_ASSERT_IMP(a_done_when_waiting, clk, rst_n, sts.done, st_r == S_WAIT)
endmodule

// ----- design/gdr_cache.sv -----
// ----------------------------------------------------------------------------
// Duplicate cache unit
// FIFO of message ids with stamps. A lookup walks stored entries one at a
// time through a single comparator, then on a miss trims to the cap and inserts
// unless the cap is zero; a tick advances time and evicts aged entries one at a time.
// ----------------------------------------------------------------------------
module gdr_cache import gdr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [8:0] max_entries,
  input  logic [15:0] dedup_ttl,
  input  cache_cmd_t cmd,
  output cache_sts_t sts
);
`include "gossip_dedup_router_assert.svh"

  typedef enum logic [2:0] {S_IDLE, S_RD, S_CMP, S_TRIM, S_INS, S_TK_RD, S_TK_CMP}
    st_t;

  logic [63:0] mem_origin [CACHE_DEPTH];
  logic [63:0] mem_seq [CACHE_DEPTH];
  logic [31:0] mem_stamp [CACHE_DEPTH];

  st_t         st_r;
  logic [IDX_W-1:0] head_r;
  logic [CNT_W-1:0] count_r, idx_r;
  logic [31:0] now_r;
  logic [63:0] key_o_r, key_s_r;
  logic [63:0] rd_o_r, rd_s_r;
  logic [31:0] rd_t_r;
  logic        done_r, hit_r;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic [CNT_W-1:0] cap;
  logic        wr_en;
  logic [31:0] age;

  // Effective cap is the register clamped to the depth.
  assign cap = (max_entries > CNT_W'(CACHE_DEPTH)) ? CNT_W'(CACHE_DEPTH)
               : CNT_W'(max_entries);
  assign rd_addr = head_r + idx_r[IDX_W-1:0];
  assign wr_addr = head_r + count_r[IDX_W-1:0];
  assign wr_en = (st_r == S_INS) && (cap != '0);
  assign age = now_r - rd_t_r;

  // Memory with one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_origin[wr_addr] <= key_o_r;
      mem_seq[wr_addr] <= key_s_r;
      mem_stamp[wr_addr] <= now_r;
    end
    rd_o_r <= mem_origin[rd_addr];
    rd_s_r <= mem_seq[rd_addr];
    rd_t_r <= mem_stamp[rd_addr];
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      head_r <= '0;
      count_r <= '0;
      idx_r <= '0;
      now_r <= '0;
      done_r <= 1'b0;
      hit_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          idx_r <= '0;
          key_o_r <= cmd.origin;
          key_s_r <= cmd.seq;
          if (cmd.lookup) begin
            st_r <= S_RD;
          end else if (cmd.tick) begin
            now_r <= now_r + 32'd1;
            st_r <= S_TK_RD;
          end
        end
        S_RD: begin
          if (idx_r == count_r) begin
            st_r <= S_TRIM;
          end else begin
            st_r <= S_CMP;
          end
        end
        S_CMP: begin
          if (rd_o_r == key_o_r && rd_s_r == key_s_r) begin
            hit_r <= 1'b1;
            done_r <= 1'b1;
            st_r <= S_IDLE;
          end else begin
            idx_r <= idx_r + CNT_W'(1);
            st_r <= S_RD;
          end
        end
        S_TRIM: begin
          // Drop oldest entries until there is room under the cap.
          if (cap == '0) begin
            count_r <= '0;
            st_r <= S_INS;
          end else if (count_r >= cap) begin
            head_r <= head_r + IDX_W'(1);
            count_r <= count_r - CNT_W'(1);
          end else begin
            st_r <= S_INS;
          end
        end
        S_INS: begin
          if (cap != '0) count_r <= count_r + CNT_W'(1);
          hit_r <= 1'b0;
          done_r <= 1'b1;
          st_r <= S_IDLE;
        end
        S_TK_RD: begin
          if (count_r == '0) begin
            hit_r <= 1'b0;
            done_r <= 1'b1;
            st_r <= S_IDLE;
          end else begin
            st_r <= S_TK_CMP;
          end
        end
        S_TK_CMP: begin
          if (age > {16'd0, dedup_ttl}) begin
            head_r <= head_r + IDX_W'(1);
            count_r <= count_r - CNT_W'(1);
            st_r <= S_TK_RD;
          end else begin
            hit_r <= 1'b0;
            done_r <= 1'b1;
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign sts.done = done_r;
  assign sts.hit = hit_r;

  `GDR_ASSERT_IMP(a_count_cap, clk, rst_n, 1'b1, count_r <= CNT_W'(CACHE_DEPTH))
  `GDR_ASSERT_NXT(a_cmp_walk, clk, rst_n, st_r == S_CMP && !done_r && idx_r < count_r,
                  st_r != S_INS)
  `GDR_ASSERT_NXT(a_done_idle, clk, rst_n, done_r, st_r == S_IDLE)
endmodule

// ----- tb/gossip_dedup_router_test.sv -----
// ----------------------------------------------------------------------------
// Gossip dedup router testbench
// Drives received, originated and tick words through the router, predicts the
// delivery and forwarding decisions with its own duplicate cache model and
// checks every result word field by field against the predicted queue.
// ----------------------------------------------------------------------------
module gossip_dedup_router_test;
  import gdr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Register index that maps to no register.
  localparam logic [2:0] REG_UNUSED = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  gdr_in_if  in_ch (clk);
  gdr_out_if out_ch (clk);

  gossip_dedup_router u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // Shadow copy of the router's registers and duplicate cache.
  logic [63:0] node_id;
  logic [8:0]  cap_reg;
  logic [15:0] ttl_reg;
  logic [7:0]  hops_reg;
  logic [63:0] seen_origin [CACHE_DEPTH];
  logic [63:0] seen_seq [CACHE_DEPTH];
  logic [31:0] seen_stamp [CACHE_DEPTH];
  int unsigned seen_head;
  int unsigned seen_count;
  logic [31:0] tick_now;
  logic [63:0] next_id;

  out_word_t   pending_words [$];
  int          error_count;
  int          send_idle_pct;
  int          recv_idle_pct;
  longint      cycle_count;
  logic [63:0] recent_origin [$];
  logic [63:0] recent_seq [$];

  // Drop the oldest cached id.
  function automatic void evict_oldest();
    if (seen_count != 0) begin
      seen_head = (seen_head + 1) % CACHE_DEPTH;
      seen_count--;
    end
  endfunction

  // Return 1 when the id is cached, else store it with the current time unless the cap is zero.
  function automatic bit seen_or_store(logic [63:0] origin, logic [63:0] seq);
    int unsigned cap;
    int unsigned slot;
    for (int unsigned i = 0; i < seen_count; i++) begin
      slot = (seen_head + i) % CACHE_DEPTH;
      if (seen_origin[slot] == origin && seen_seq[slot] == seq) return 1'b1;
    end
    cap = (cap_reg > CACHE_DEPTH) ? CACHE_DEPTH : cap_reg;
    if (cap == 0) begin
      seen_count = 0;
      return 1'b0;
    end
    while (seen_count >= cap) evict_oldest();
    slot = (seen_head + seen_count) % CACHE_DEPTH;
    seen_origin[slot] = origin;
    seen_seq[slot] = seq;
    seen_stamp[slot] = tick_now;
    seen_count++;
    return 1'b0;
  endfunction

  function automatic out_word_t make_word(logic [1:0] act, logic dup, logic [63:0] src,
      logic [63:0] dst, logic [63:0] origin, logic [63:0] seq, logic [7:0] ttl,
      logic [7:0] exc, logic has_exc);
    out_word_t w;
    w.action = act; w.was_duplicate = dup; w.out_src = src; w.out_dst = dst;
    w.out_origin = origin; w.out_seq = seq; w.out_ttl = ttl;
    w.except_link = exc; w.has_except = has_exc; w.last = 1'b0;
    return w;
  endfunction

  // Work out the decision words for one accepted input word.
  function automatic void predict_route(in_word_t iw);
    out_word_t res [$];
    out_word_t w;
    case (iw.func)
      FUNC_RECV: begin
        if (seen_or_store(iw.msg_origin, iw.msg_seq)) begin
          res = {res, make_word(ACT_NONE, 1'b1, 0, 0, 0, 0, 0, 0, 1'b0)};
        end else if (iw.dst_id == 0) begin
          if (iw.src_id != node_id)
            res = {res, make_word(ACT_LOCAL, 1'b0, iw.src_id, 0, iw.msg_origin,
                                  iw.msg_seq, 0, 0, 1'b0)};
          if (iw.hop_ttl > 1)
            res = {res, make_word(ACT_FLOOD, 1'b0, iw.src_id, 0, iw.msg_origin,
                                  iw.msg_seq, iw.hop_ttl - 8'd1, iw.inbound_link, 1'b1)};
        end else if (iw.dst_id == node_id) begin
          res = {res, make_word(ACT_LOCAL, 1'b0, iw.src_id, iw.dst_id, iw.msg_origin,
                                iw.msg_seq, 0, 0, 1'b0)};
        end else if (iw.hop_ttl > 1) begin
          res = {res, make_word(ACT_ROUTE, 1'b0, iw.src_id, iw.dst_id, iw.msg_origin,
                                iw.msg_seq, iw.hop_ttl - 8'd1, iw.inbound_link, 1'b1)};
        end
      end
      FUNC_BCAST: begin
        next_id++;
        void'(seen_or_store(node_id, next_id));
        res = {res, make_word(ACT_FLOOD, 1'b0, node_id, 0, node_id, next_id,
                              hops_reg, 0, 1'b0)};
      end
      FUNC_TARG: begin
        if (iw.dst_id == node_id) begin
          res = {res, make_word(ACT_LOCAL, 1'b0, node_id, node_id, 0, 0, 0, 0, 1'b0)};
        end else begin
          next_id++;
          void'(seen_or_store(node_id, next_id));
          res = {res, make_word(ACT_ROUTE, 1'b0, node_id, iw.dst_id, node_id, next_id,
                                hops_reg, 0, 1'b0)};
        end
      end
      default: begin
        tick_now++;
        while (seen_count > 0 && (tick_now - seen_stamp[seen_head]) > {16'd0, ttl_reg})
          evict_oldest();
      end
    endcase
    if (res.size() == 0) res = {res, make_word(ACT_NONE, 1'b0, 0, 0, 0, 0, 0, 0, 1'b0)};
    res[res.size() - 1].last = 1'b1;
    pending_words = {pending_words, res};
  endfunction

  // Send one word, with random idle cycles before it.
  task automatic send_word(in_word_t iw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= iw;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_route(iw);
  endtask

  // Wait for all results and the block to settle, then write one register.
  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    in_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (520) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SELF: node_id = val;
      REG_MAX:  cap_reg = val[8:0];
      REG_TTL:  ttl_reg = val[15:0];
      REG_HOPS: hops_reg = val[7:0];
      REG_SEED: next_id = val;
      default: ;
    endcase
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic in_word_t make_in(logic [1:0] f, logic [63:0] origin, logic [63:0] seq,
      logic [63:0] src, logic [63:0] dst, logic [7:0] hops, logic [7:0] link);
    in_word_t iw;
    iw.func = f; iw.msg_origin = origin; iw.msg_seq = seq; iw.src_id = src;
    iw.dst_id = dst; iw.hop_ttl = hops; iw.inbound_link = link;
    return iw;
  endfunction

  // Random word, mostly well-formed traffic with replays of recent ids.
  task automatic send_random();
    in_word_t iw;
    int unsigned pick;
    int unsigned k;
    iw = make_in($urandom_range(3), rand64(), rand64(), rand64(), rand64(),
                 $urandom_range(255), $urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 45) begin
      iw.func = FUNC_RECV;
      if (recent_origin.size() != 0 && $urandom_range(2) == 0) begin
        k = $urandom_range(recent_origin.size() - 1);
        iw.msg_origin = recent_origin[k];
        iw.msg_seq = recent_seq[k];
      end
      case ($urandom_range(5))
        0, 1: iw.dst_id = 0;
        2: iw.dst_id = node_id;
        default: ;
      endcase
      if ($urandom_range(4) == 0) iw.src_id = node_id;
      if ($urandom_range(3) == 0) iw.hop_ttl = $urandom_range(2);
    end else if (pick < 60) begin
      iw.func = FUNC_BCAST;
    end else if (pick < 75) begin
      iw.func = FUNC_TARG;
      if ($urandom_range(4) == 0) iw.dst_id = node_id;
      else if ($urandom_range(6) == 0) iw.dst_id = 0;
    end else begin
      iw.func = FUNC_TICK;
    end
    if (iw.func == FUNC_RECV) begin
      recent_origin = {recent_origin, iw.msg_origin};
      recent_seq = {recent_seq, iw.msg_seq};
      if (recent_origin.size() > 40) begin
        recent_origin = recent_origin[1:$];
        recent_seq = recent_seq[1:$];
      end
    end
    send_word(iw);
  endtask

  // Extremes of every field and each special case of the router.
  task automatic test_directed();
    write_reg(REG_SELF, 64'h0123_4567_89AB_CDEF);
    write_reg(REG_SEED, 64'hFFFF_FFFF_FFFF_FFFE);
    write_reg(REG_HOPS, 8'd0);
    send_word(make_in(FUNC_RECV, 0, 0, 0, 0, 0, 0));
    send_word(make_in(FUNC_RECV, '1, '1, '1, 0, 8'hFF, 8'hFF));
    send_word(make_in(FUNC_RECV, '1, '1, 5, 0, 8'hFF, 8'hFF));
    send_word(make_in(FUNC_RECV, 7, 7, node_id, 0, 8'd1, 3));
    send_word(make_in(FUNC_RECV, 8, 8, node_id, 0, 8'd2, 4));
    send_word(make_in(FUNC_RECV, 9, 9, 1, node_id, 8'd5, 5));
    send_word(make_in(FUNC_RECV, 10, 10, 1, 64'hAA, 8'd2, 8'h80));
    send_word(make_in(FUNC_RECV, 11, 11, 1, '1, 8'd1, 8'h01));
    send_word(make_in(FUNC_BCAST, 0, 0, 0, 0, 0, 0));
    send_word(make_in(FUNC_BCAST, '1, '1, '1, '1, '1, '1));
    send_word(make_in(FUNC_TARG, 0, 0, 0, node_id, 0, 0));
    send_word(make_in(FUNC_TARG, 0, 0, 0, 0, 0, 0));
    send_word(make_in(FUNC_TARG, 0, 0, 0, '1, 0, 0));
    send_word(make_in(FUNC_RECV, node_id, 64'd1, 3, 0, 8'd9, 2));
    send_word(make_in(FUNC_TICK, '1, '1, '1, '1, '1, '1));
    write_reg(REG_HOPS, 8'd1);
    send_word(make_in(FUNC_BCAST, 0, 0, 0, 0, 0, 0));
    write_reg(REG_HOPS, 8'hFF);
    send_word(make_in(FUNC_TARG, 0, 0, 0, 64'h55, 0, 0));
  endtask

  // Cap at zero, one and above the cache depth, plus lowering the cap.
  task automatic test_cache_cap();
    write_reg(REG_MAX, 9'd0);
    send_word(make_in(FUNC_RECV, 1, 1, 2, 0, 8'd3, 1));
    send_word(make_in(FUNC_RECV, 1, 1, 2, 0, 8'd3, 1));
    write_reg(REG_MAX, 9'd1);
    send_word(make_in(FUNC_RECV, 1, 1, 2, 0, 8'd3, 1));
    send_word(make_in(FUNC_RECV, 1, 2, 2, 0, 8'd3, 1));
    send_word(make_in(FUNC_RECV, 1, 1, 2, 0, 8'd3, 1));
    write_reg(REG_MAX, 9'd511);
    for (int i = 0; i < 12; i++) send_word(make_in(FUNC_RECV, 3, i, 2, 0, 8'd3, 1));
    write_reg(REG_MAX, 9'd4);
    send_word(make_in(FUNC_RECV, 3, 100, 2, 0, 8'd3, 1));
    send_word(make_in(FUNC_RECV, 3, 0, 2, 0, 8'd3, 1));
    send_word(make_in(FUNC_RECV, 3, 11, 2, 0, 8'd3, 1));
  endtask

  // Aging out with a time-to-live of one.
  task automatic test_aging();
    write_reg(REG_TTL, 16'd1);
    send_word(make_in(FUNC_RECV, 4, 4, 2, 0, 8'd3, 1));
    send_word(make_in(FUNC_TICK, 0, 0, 0, 0, 0, 0));
    send_word(make_in(FUNC_RECV, 4, 4, 2, 0, 8'd3, 1));
    send_word(make_in(FUNC_TICK, 0, 0, 0, 0, 0, 0));
    send_word(make_in(FUNC_TICK, 0, 0, 0, 0, 0, 0));
    send_word(make_in(FUNC_RECV, 4, 4, 2, 0, 8'd3, 1));
    write_reg(REG_TTL, 16'hFFFF);
  endtask

  // Random traffic under one register setting and idle pattern.
  task automatic test_random_phase(int n, int s_idle, int r_idle, logic [8:0] cap,
                                   logic [15:0] ttl);
    write_reg(REG_MAX, cap);
    write_reg(REG_TTL, ttl);
    write_reg(REG_HOPS, $urandom_range(255));
    write_reg(REG_SELF, ($urandom_range(1) == 0) ? 64'd0 : rand64());
    write_reg(REG_SEED, ($urandom_range(3) == 0) ? 64'hFFFF_FFFF_FFFF_FFF0 : rand64());
    write_reg(REG_UNUSED, rand64());
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int i = 0; i < n; i++) send_random();
  endtask

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    out_word_t exp_w;
    out_word_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (pending_words.size() == 0) begin
        $error("unexpected result word action=%0d", got.action);
        error_count++;
      end else begin
        exp_w = pending_words[0];
        pending_words.delete(0);
        if (got.action !== exp_w.action) begin
          $error("action: expected %0d, got %0d", exp_w.action, got.action); error_count++;
        end
        if (got.was_duplicate !== exp_w.was_duplicate) begin
          $error("was_duplicate: expected %0d, got %0d", exp_w.was_duplicate,
                 got.was_duplicate); error_count++;
        end
        if (got.out_src !== exp_w.out_src) begin
          $error("out_src: expected %h, got %h", exp_w.out_src, got.out_src); error_count++;
        end
        if (got.out_dst !== exp_w.out_dst) begin
          $error("out_dst: expected %h, got %h", exp_w.out_dst, got.out_dst); error_count++;
        end
        if (got.out_origin !== exp_w.out_origin) begin
          $error("out_origin: expected %h, got %h", exp_w.out_origin, got.out_origin);
          error_count++;
        end
        if (got.out_seq !== exp_w.out_seq) begin
          $error("out_seq: expected %h, got %h", exp_w.out_seq, got.out_seq); error_count++;
        end
        if (got.out_ttl !== exp_w.out_ttl) begin
          $error("out_ttl: expected %0d, got %0d", exp_w.out_ttl, got.out_ttl); error_count++;
        end
        if (got.except_link !== exp_w.except_link) begin
          $error("except_link: expected %0d, got %0d", exp_w.except_link, got.except_link);
          error_count++;
        end
        if (got.has_except !== exp_w.has_except) begin
          $error("has_except: expected %0d, got %0d", exp_w.has_except, got.has_except);
          error_count++;
        end
        if (got.last !== exp_w.last) begin
          $error("last: expected %0d, got %0d", exp_w.last, got.last); error_count++;
        end
      end
    end
  end

  // Receiver stalls at random.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 10_000_000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    error_count = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    node_id = 0; cap_reg = 9'd256; ttl_reg = 16'd60; hops_reg = 8'd8;
    next_id = 0;
    seen_head = 0; seen_count = 0; tick_now = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_cache_cap();
    test_aging();
    test_random_phase(550, 23, 60, 9'd256, 16'd60);
    test_random_phase(550, 60, 23, 9'd3, 16'd2);
    test_random_phase(550, 0, 0, 9'd40, 16'd5);
    in_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
